>>> hdl/dbs_pkg.sv
// Shared definitions for the depth band segmenter: field widths,
// configuration register indexes and the structs passed between modules.
// No dependencies.
`default_nettype none

package dbs_pkg;

  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned DIM_CFG_W   = 11;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned MAX_DIM_DEF = 1024;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd4;

  localparam logic [DEPTH_W-1:0]   NEAR_RST   = 16'd0;
  localparam logic [DEPTH_W-1:0]   FAR_RST    = 16'hFFFF;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 11'd480;

  typedef struct packed {
    logic [DEPTH_W-1:0]   near_thr;
    logic [DEPTH_W-1:0]   far_thr;
    logic [DIM_CFG_W-1:0] width;
    logic [DIM_CFG_W-1:0] height;
    logic                 mirror;
  } cfg_t;

  // raster position flags from the scan counters to the band logic
  typedef struct packed {
    logic first;  // first pixel of a frame
    logic done;   // last pixel of a frame
  } pos_t;

endpackage

`default_nettype wire

>>> hdl/dbs_cfg_regs.sv
// Configuration register file of the depth band segmenter.
// Depends on dbs_pkg.
`default_nettype none

module dbs_cfg_regs
  import dbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NEAR:   cfg_nxt.near_thr = cfg_wdata;
        REG_FAR:    cfg_nxt.far_thr  = cfg_wdata;
        REG_WIDTH:  cfg_nxt.width    = cfg_wdata[DIM_CFG_W-1:0];
        REG_HEIGHT: cfg_nxt.height   = cfg_wdata[DIM_CFG_W-1:0];
        REG_MIRROR: cfg_nxt.mirror   = cfg_wdata[0];
        default:    cfg_nxt          = cfg_r;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_thr <= NEAR_RST;
      cfg_r.far_thr  <= FAR_RST;
      cfg_r.width    <= WIDTH_RST;
      cfg_r.height   <= HEIGHT_RST;
      cfg_r.mirror   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/dbs_scan.sv
// Raster scan counters: column and row position, destination coordinates
// with optional column mirroring, and frame start and end flags.
// Depends on dbs_pkg.
`default_nettype none

module dbs_scan
  import dbs_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  cfg_t                    cfg,
  output pos_t                    pos,
  output logic [COORD_W-1:0]      dest_column,
  output logic [COORD_W-1:0]      dest_row
);

  localparam int unsigned DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CMP_W = (DIM_W + 1 > DIM_CFG_W) ? DIM_W + 1 : DIM_CFG_W;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0] w_ext, h_ext;
  logic [DIM_W-1:0] wm1, hm1;
  logic             last_col, last_row;
  logic [DIM_W-1:0] col_eff, row_eff, dcol;
  logic [31:0]      dcol_wide, row_wide;

  // clamp the programmed size to 1..MAX_DIM, kept as size minus one
  always_comb begin
    w_ext = CMP_W'(cfg.width);
    h_ext = CMP_W'(cfg.height);
    if (w_ext == '0)                   wm1 = '0;
    else if (w_ext > CMP_W'(MAX_DIM))  wm1 = DIM_W'(MAX_DIM - 1);
    else                               wm1 = DIM_W'(w_ext - CMP_W'(1));
    if (h_ext == '0)                   hm1 = '0;
    else if (h_ext > CMP_W'(MAX_DIM))  hm1 = DIM_W'(MAX_DIM - 1);
    else                               hm1 = DIM_W'(h_ext - CMP_W'(1));
  end

  always_comb begin
    // a counter past a shrunken size counts as on the last column or row
    last_col  = (col_r >= wm1);
    last_row  = (row_r >= hm1);
    col_eff   = last_col ? wm1 : col_r;
    row_eff   = last_row ? hm1 : row_r;
    dcol      = cfg.mirror ? (wm1 - col_eff) : col_eff;
    pos.first = (col_r == '0) && (row_r == '0);
    pos.done  = last_col && last_row;
    dcol_wide = 32'(dcol);
    row_wide  = 32'(row_eff);
    dest_column = dcol_wide[COORD_W-1:0];
    dest_row    = row_wide[COORD_W-1:0];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (pos.done) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_eff + DIM_W'(1);
      end else begin
        col_nxt = col_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dbs_band.sv
// Depth band thresholding with the running in-band minimum and maximum,
// and the frame extremes reported on the last pixel.
// Depends on dbs_pkg.
`default_nettype none

module dbs_band
  import dbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               step,
  input  cfg_t                    cfg,
  input  pos_t                    pos,
  input  wire logic [DEPTH_W-1:0] depth_in,
  output logic [DEPTH_W-1:0]      depth_out,
  output logic [DEPTH_W-1:0]      frame_min,
  output logic [DEPTH_W-1:0]      frame_max
);

  logic [DEPTH_W-1:0] min_r, min_nxt;
  logic [DEPTH_W-1:0] max_r, max_nxt;
  logic [DEPTH_W-1:0] cur_min, cur_max;
  logic [DEPTH_W-1:0] px_lo;
  logic               below, above;

  always_comb begin
    // extremes restart from the thresholds on the first pixel of a frame
    cur_min = pos.first ? cfg.far_thr  : min_r;
    cur_max = pos.first ? cfg.near_thr : max_r;

    // near check first; its zeroed value then meets the far check
    below   = (depth_in < cfg.near_thr);
    px_lo   = below ? '0 : depth_in;
    min_nxt = (!below && (depth_in < cur_min)) ? depth_in : cur_min;

    above     = (px_lo > cfg.far_thr);
    depth_out = above ? '0 : px_lo;
    max_nxt   = (!above && (px_lo > cur_max)) ? px_lo : cur_max;

    frame_min = '0;
    frame_max = '0;
    if (pos.done) begin
      // untouched extremes report the opposite threshold
      frame_min = (min_nxt == cfg.far_thr)  ? cfg.near_thr : min_nxt;
      frame_max = (max_nxt == cfg.near_thr) ? cfg.far_thr  : max_nxt;
    end
  end

  // reloaded on every frame start, so no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/depth_band_segmenter_unit.sv
// Top level of the depth band segmenter: input register, scan and band
// logic, result register. Depends on dbs_pkg, dbs_cfg_regs, dbs_scan, dbs_band.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | in_depth_in
//  out     | out_valid/out_ready| out_depth_out, out_dest_column, out_dest_row,
//          |                    | out_frame_done, out_frame_min, out_frame_max
//  cfg     | cfg_we             | cfg_index, cfg_wdata
//
// One request per clock while the output is not stalled; a request is taken
// into the input register, which feeds the result register directly.
// Scan counters and min/max advance as a pixel moves into the result register.
// Synchronous active-low reset empties both registers and restarts the scan.
// A stalled output holds its result; the input register keeps taking
// requests until it too is full.
`default_nettype none

module depth_band_segmenter_unit
  import dbs_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DEPTH_W-1:0]    in_depth_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DEPTH_W-1:0]         out_depth_out,
  output logic [COORD_W-1:0]         out_dest_column,
  output logic [COORD_W-1:0]         out_dest_row,
  output logic                       out_frame_done,
  output logic [DEPTH_W-1:0]         out_frame_min,
  output logic [DEPTH_W-1:0]         out_frame_max
);

  cfg_t cfg;
  pos_t pos;

  logic               s1_valid_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic               s1_move;

  logic [DEPTH_W-1:0] depth_seg, fmin, fmax;
  logic [COORD_W-1:0] dcol, drow;

  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_depth_r, out_min_r, out_max_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic               out_done_r;

  dbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbs_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_move),
    .cfg         (cfg),
    .pos         (pos),
    .dest_column (dcol),
    .dest_row    (drow)
  );

  dbs_band u_band (
    .clk       (clk),
    .step      (s1_move),
    .cfg       (cfg),
    .pos       (pos),
    .depth_in  (s1_depth_r),
    .depth_out (depth_seg),
    .frame_min (fmin),
    .frame_max (fmax)
  );

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (!out_valid_r || out_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_depth_r <= in_depth_in;
    if (s1_move) begin
      out_depth_r <= depth_seg;
      out_col_r   <= dcol;
      out_row_r   <= drow;
      out_done_r  <= pos.done;
      out_min_r   <= fmin;
      out_max_r   <= fmax;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_depth_out   = out_depth_r;
  assign out_dest_column = out_col_r;
  assign out_dest_row    = out_row_r;
  assign out_frame_done  = out_done_r;
  assign out_frame_min   = out_min_r;
  assign out_frame_max   = out_max_r;

endmodule

`default_nettype wire

>>> hdl/dbs_checker.sv
// Port-level checks for the depth band segmenter, bound to the top level.
// Depends on dbs_pkg and depth_band_segmenter_unit.
`default_nettype none

module dbs_checker
  import dbs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [DEPTH_W-1:0] out_depth_out,
  input wire logic               out_frame_done,
  input wire logic [DEPTH_W-1:0] out_frame_min,
  input wire logic [DEPTH_W-1:0] out_frame_max
);

  // extremes are only reported with the frame end
  a_extremes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_done) |-> (out_frame_min == '0 && out_frame_max == '0))
    else $error("frame extremes non-zero outside frame end");

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_depth_out) && $stable(out_frame_done)))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  // the input stalls only while a result is pending
  a_input_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> out_valid)
    else $error("input stalled while no result pending");

endmodule

bind depth_band_segmenter_unit dbs_checker u_dbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_depth_out  (out_depth_out),
  .out_frame_done (out_frame_done),
  .out_frame_min  (out_frame_min),
  .out_frame_max  (out_frame_max)
);

`default_nettype wire
